@@ rtl/crcdf_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the frame deframer.
`timescale 1ns / 1ps

package crcdf_pkg;

   // Frame format
   localparam logic [7:0] SYNC_A = 8'h40;
   localparam logic [7:0] SYNC_B = 8'h3A;
   localparam logic [7:0] TAIL_A = 8'h0D;
   localparam logic [7:0] TAIL_B = 8'h0A;
   localparam int HEADER_LEN  = 35;
   localparam int MAX_PAYLOAD = 1024;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Width that holds any legal frame length (header plus largest payload)
   localparam int LEN_W = $clog2(HEADER_LEN + MAX_PAYLOAD + 1);

   // Result kinds
   localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
   localparam logic [2:0] KIND_GOOD     = 3'd1;
   localparam logic [2:0] KIND_CRC_ERR  = 3'd2;
   localparam logic [2:0] KIND_TAIL_ERR = 3'd3;
   localparam logic [2:0] KIND_LEN_ERR  = 3'd4;

   // One result word
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data;
      logic [15:0] func_code;
   } rsp_item_type;

   // CRC-16/XMODEM update by one byte, MSB first
   function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                              input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/crcdf_parser.sv @@
// Frame parser: sync hunt, length check, header, payload, CRC and tail check.
`timescale 1ns / 1ps

module crcdf_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              rx_byte,
   output logic                    res_valid,
   output crcdf_pkg::rsp_item_type res_item
);

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_SYNC2 = 3'd1;
   localparam logic [2:0] PH_LEN   = 3'd2;
   localparam logic [2:0] PH_BODY  = 3'd3;
   localparam logic [2:0] PH_CRC   = 3'd4;
   localparam logic [2:0] PH_TAIL  = 3'd5;

   localparam int LW = crcdf_pkg::LEN_W;

   logic [2:0]    phase_ff, phase_in;
   logic [LW-1:0] count_ff, count_in;
   logic [LW-1:0] frame_len_ff, frame_len_in;
   logic [7:0]    len_hi_ff, len_hi_in;
   logic [15:0]   crc_ff, crc_in;
   logic [15:0]   func_ff, func_in;
   logic [7:0]    hold_ff, hold_in;

   logic [15:0]   full_len;
   logic          len_bad;
   logic [LW-1:0] count_inc;

   assign full_len  = {len_hi_ff, rx_byte};
   assign len_bad   = (full_len < 16'(crcdf_pkg::HEADER_LEN)) ||
                      ({1'b0, full_len} >
                       17'(crcdf_pkg::HEADER_LEN + crcdf_pkg::MAX_PAYLOAD));
   assign count_inc = count_ff + 1'b1;

   // Advance the parse by one received word
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      frame_len_in = frame_len_ff;
      len_hi_in    = len_hi_ff;
      crc_in       = crc_ff;
      func_in      = func_ff;
      hold_in      = hold_ff;
      res_valid    = 1'b0;
      res_item     = '0;
      case (phase_ff)
         PH_SYNC2: begin
            if (rx_byte == crcdf_pkg::SYNC_B) begin
               phase_in = PH_LEN;
               count_in = '0;
               crc_in   = '0;
               func_in  = '0;
               hold_in  = '0;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_LEN: begin
            if (count_ff == '0) begin
               len_hi_in = rx_byte;
               count_in  = LW'(1);
            end else begin
               count_in = '0;
               if (len_bad) begin
                  phase_in       = PH_HUNT;
                  res_valid      = 1'b1;
                  res_item.kind  = crcdf_pkg::KIND_LEN_ERR;
               end else begin
                  frame_len_in = full_len[LW-1:0];
                  phase_in     = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            crc_in = crcdf_pkg::crc_update(crc_ff, rx_byte);
            // Capture the function code from the last two header bytes
            if (count_ff == LW'(crcdf_pkg::HEADER_LEN - 2)) begin
               func_in = {rx_byte, 8'h00};
            end else if (count_ff == LW'(crcdf_pkg::HEADER_LEN - 1)) begin
               func_in = {func_ff[15:8], rx_byte};
            end
            if (count_inc >= frame_len_ff) begin
               phase_in = PH_CRC;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
            if (count_ff >= LW'(crcdf_pkg::HEADER_LEN)) begin
               res_valid     = 1'b1;
               res_item.kind = crcdf_pkg::KIND_PAYLOAD;
               res_item.data = rx_byte;
            end
         end
         PH_CRC: begin
            if (count_ff == '0) begin
               hold_in  = rx_byte;
               count_in = LW'(1);
            end else begin
               // Fold received CRC in: zero means match
               crc_in   = crc_ff ^ {hold_ff, rx_byte};
               count_in = '0;
               phase_in = PH_TAIL;
            end
         end
         PH_TAIL: begin
            if (count_ff == '0) begin
               hold_in  = rx_byte;
               count_in = LW'(1);
            end else begin
               count_in  = '0;
               phase_in  = PH_HUNT;
               res_valid = 1'b1;
               res_item.func_code = func_ff;
               if (hold_ff != crcdf_pkg::TAIL_A || rx_byte != crcdf_pkg::TAIL_B) begin
                  res_item.kind = crcdf_pkg::KIND_TAIL_ERR;
               end else if (crc_ff != '0) begin
                  res_item.kind = crcdf_pkg::KIND_CRC_ERR;
               end else begin
                  res_item.kind = crcdf_pkg::KIND_GOOD;
               end
            end
         end
         default: begin
            phase_in = (rx_byte == crcdf_pkg::SYNC_A) ? PH_SYNC2 : PH_HUNT;
         end
      endcase
   end

   // Hold state between words
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         frame_len_ff <= frame_len_in;
         len_hi_ff    <= len_hi_in;
         crc_ff       <= crc_in;
         func_ff      <= func_in;
         hold_ff      <= hold_in;
      end
   end

endmodule

@@ rtl/crc_checked_frame_deframer.sv @@
// Top level: byte stream in, payload and status words out through a two-word queue.
// Result words are written into the registered queue when the byte that causes them is accepted.
// Throughput: one byte per cycle while the result queue is not full; the two-entry
// result queue keeps input flowing while one result word waits on a stalled output.
// Reset: synchronous, active high; the parser returns to sync hunting and the
// result queue empties.
`timescale 1ns / 1ps

module crc_checked_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [23:8] func_code
   output logic [2:0]  rsp_tuser    // [2:0] out_kind
);

   logic                    req_accept;
   logic                    res_valid;
   crcdf_pkg::rsp_item_type res_item;

   crcdf_pkg::rsp_item_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign req_tready = (count_ff != 2'd2);
   assign req_accept = req_tvalid && req_tready;

   crcdf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (req_accept),
      .rx_byte   (req_tdata),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   assign push = req_accept && res_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   // Queue result words
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= res_item;
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {slot_ff[rd_ptr_ff].func_code, slot_ff[rd_ptr_ff].data};
   assign rsp_tuser  = slot_ff[rd_ptr_ff].kind;

   // Checks
   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("result queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("result word lost on push");

   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> count_ff == 2'd2)
      else $error("input stalled with queue space free");

endmodule
